@@ design/json_byte_tokenizer_unit_defines.svh @@
`ifndef JSON_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define JBT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define JBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/jbt_pkg.sv @@
package jbt_pkg;

    // internal counter width, outputs carry the low 32 bits
    localparam int CNT_W = 32;
    typedef logic [CNT_W-1:0] t_cnt;
    localparam t_cnt CNT_MAX = '1;

    // result queue geometry (power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        RK_TOKEN = 2'd0,
        RK_ERROR = 2'd1,
        RK_DONE  = 2'd2
    } t_res_kind;

    typedef enum logic [3:0] {
        TK_NONE     = 4'd0,
        TK_STRING   = 4'd1,
        TK_NUMBER   = 4'd2,
        TK_COMMA    = 4'd3,
        TK_COLON    = 4'd4,
        TK_LBRACE   = 4'd5,
        TK_RBRACE   = 4'd6,
        TK_LBRACKET = 4'd7,
        TK_RBRACKET = 4'd8,
        TK_TRUE     = 4'd9,
        TK_FALSE    = 4'd10,
        TK_NULL     = 4'd11
    } t_tok_kind;

    // keyword selector codes
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // characters the lexer looks at
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOW_E    = 8'h65;
    localparam logic [7:0] CH_UP_E     = 8'h45;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;

    typedef struct packed {
        t_res_kind  result_kind;
        t_tok_kind  token_kind;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic [31:0] line_number;
        logic [31:0] column_number;
        logic [31:0] token_index;
        logic [7:0]  bad_byte;
        logic        last;
    } t_result;

    // up to two results produced by one byte
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_res_pair;

    function automatic t_cnt sat_inc(t_cnt x);
        return (x == CNT_MAX) ? x : t_cnt'(x + 1'b1);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_number_byte(logic [7:0] b);
        return is_digit(b) || (b == CH_MINUS) || (b == CH_PLUS) || (b == CH_DOT) ||
               (b == CH_LOW_E) || (b == CH_UP_E);
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] sel);
        return (sel == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    // expected letter of a keyword at a given step
    function automatic logic [7:0] kw_char(logic [1:0] sel, logic [2:0] step);
        logic [7:0] ch;
        ch = 8'h00;
        case (sel)
            KW_FALSE: begin
                case (step)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    3'd4:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_NULL: begin
                case (step)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    3'd2:    ch = "l";
                    3'd3:    ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (step)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    3'd3:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic t_result make_result(t_res_kind rk, t_tok_kind tk, t_cnt s, t_cnt e,
                                            t_cnt row, t_cnt col, t_cnt tidx,
                                            logic [7:0] bad);
        t_result r;
        r.result_kind   = rk;
        r.token_kind    = tk;
        r.start_pos     = 32'(s);
        r.end_pos       = 32'(e);
        r.line_number   = 32'(row);
        r.column_number = 32'(col);
        r.token_index   = 32'(tidx);
        r.bad_byte      = bad;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

@@ design/jbt_ifs.sv @@
// byte input channel
interface jbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

// result channel
interface jbt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [3:0]  token_kind;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [31:0] line_number;
    logic [31:0] column_number;
    logic [31:0] token_index;
    logic [7:0]  bad_byte;
    logic        last;

    modport source (
        output valid, output result_kind, output token_kind, output start_pos,
        output end_pos, output line_number, output column_number,
        output token_index, output bad_byte, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input token_kind, input start_pos,
        input end_pos, input line_number, input column_number,
        input token_index, input bad_byte, input last, output ready
    );
endinterface

@@ design/jbt_lexer_core.sv @@
module jbt_lexer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_input,
    output jbt_pkg::t_res_pair o_res
);
    import jbt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_KEYWORD = 3'd4,
        MODE_ERROR   = 3'd5,
        MODE_DONE    = 3'd6
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [1:0] r_kw_sel, n_kw_sel;
    logic [2:0] r_kw_step, n_kw_step;
    t_cnt       r_pos, n_pos;
    t_cnt       r_row, n_row;
    t_cnt       r_col, n_col;
    t_cnt       r_tok_start, n_tok_start;
    t_cnt       r_tok_col, n_tok_col;
    t_cnt       r_tok_cnt, n_tok_cnt;

    t_result    res0, res1;
    logic [1:0] rcnt;

    // per-byte scan step
    always_comb begin
        t_cnt       p;
        t_cnt       col;
        logic       do_disp;
        logic       d_en;
        t_result    d_res;
        t_tok_kind  single;
        logic [1:0] sel;
        logic [2:0] st;
        logic [2:0] st_nx;
        logic [7:0] b;

        n_mode      = r_mode;
        n_kw_sel    = r_kw_sel;
        n_kw_step   = r_kw_step;
        n_pos       = r_pos;
        n_row       = r_row;
        n_col       = r_col;
        n_tok_start = r_tok_start;
        n_tok_col   = r_tok_col;
        n_tok_cnt   = r_tok_cnt;
        res0        = '0;
        res1        = '0;
        rcnt        = 2'd0;
        do_disp     = 1'b0;
        d_en        = 1'b0;
        d_res       = '0;
        single      = TK_NONE;
        b           = i_data_byte;
        p           = sat_inc(r_pos);
        col         = sat_inc(r_col);
        sel         = (r_kw_sel == KW_FALSE || r_kw_sel == KW_NULL) ? r_kw_sel : KW_TRUE;
        st          = r_kw_step;
        st_nx       = st + 3'd1;

        if (i_step && r_mode != MODE_ERROR && r_mode != MODE_DONE) begin
            if (i_end_of_input) begin
                // end of text: flush a pending number, then finish or fail
                if (r_mode == MODE_NUMBER) begin
                    res0 = make_result(RK_TOKEN, TK_NUMBER, r_tok_start, r_pos, r_row,
                                       r_tok_col, r_tok_cnt, 8'h00);
                    n_tok_cnt = sat_inc(r_tok_cnt);
                    res1 = make_result(RK_DONE, TK_NONE, r_pos, r_pos, r_row, r_col,
                                       n_tok_cnt, 8'h00);
                    rcnt   = 2'd2;
                    n_mode = MODE_DONE;
                end else if (r_mode == MODE_IDLE) begin
                    res0 = make_result(RK_DONE, TK_NONE, r_pos, r_pos, r_row, r_col,
                                       r_tok_cnt, 8'h00);
                    rcnt   = 2'd1;
                    n_mode = MODE_DONE;
                end else begin
                    res0 = make_result(RK_ERROR, TK_NONE, r_pos, r_pos, r_row, r_col,
                                       r_tok_cnt, 8'h00);
                    rcnt   = 2'd1;
                    n_mode = MODE_ERROR;
                end
            end else begin
                n_pos = p;
                n_col = col;
                case (r_mode)
                    MODE_STRING: begin
                        if (b == CH_QUOTE) begin
                            res0 = make_result(RK_TOKEN, TK_STRING, r_tok_start,
                                               t_cnt'(p - 1'b1), r_row, r_tok_col,
                                               r_tok_cnt, 8'h00);
                            n_tok_cnt = sat_inc(r_tok_cnt);
                            rcnt      = 2'd1;
                            n_mode    = MODE_IDLE;
                        end else if (b == CH_BSLASH) begin
                            n_mode = MODE_ESCAPE;
                        end else if (b == CH_NL || b == CH_CR) begin
                            res0 = make_result(RK_ERROR, TK_NONE, p, p, r_row, col,
                                               r_tok_cnt, b);
                            rcnt   = 2'd1;
                            n_mode = MODE_ERROR;
                        end
                    end
                    MODE_ESCAPE: begin
                        n_mode = MODE_STRING;
                    end
                    MODE_KEYWORD: begin
                        if (st < kw_len(sel) && b == kw_char(sel, st)) begin
                            n_kw_step = st_nx;
                            if (st_nx >= kw_len(sel)) begin
                                res0 = make_result(RK_TOKEN,
                                                   t_tok_kind'(4'(TK_TRUE) + 4'(sel)),
                                                   r_tok_start, p, r_row, r_tok_col,
                                                   r_tok_cnt, 8'h00);
                                n_tok_cnt = sat_inc(r_tok_cnt);
                                rcnt      = 2'd1;
                                n_mode    = MODE_IDLE;
                            end
                        end else begin
                            res0 = make_result(RK_ERROR, TK_NONE, p, p, r_row, col,
                                               r_tok_cnt, b);
                            rcnt   = 2'd1;
                            n_mode = MODE_ERROR;
                        end
                    end
                    MODE_NUMBER: begin
                        // a non-number byte closes the number and is then dispatched
                        if (!is_number_byte(b)) begin
                            res0 = make_result(RK_TOKEN, TK_NUMBER, r_tok_start,
                                               t_cnt'(p - 1'b1), r_row, r_tok_col,
                                               r_tok_cnt, 8'h00);
                            n_tok_cnt = sat_inc(r_tok_cnt);
                            rcnt      = 2'd1;
                            do_disp   = 1'b1;
                        end
                    end
                    default: begin
                        do_disp = 1'b1;
                    end
                endcase
            end
        end

        // idle dispatch of a byte
        if (do_disp) begin
            n_mode = MODE_IDLE;
            case (b)
                CH_LBRACE:   single = TK_LBRACE;
                CH_RBRACE:   single = TK_RBRACE;
                CH_LBRACKET: single = TK_LBRACKET;
                CH_RBRACKET: single = TK_RBRACKET;
                CH_COMMA:    single = TK_COMMA;
                CH_COLON:    single = TK_COLON;
                default:     single = TK_NONE;
            endcase
            if (single != TK_NONE) begin
                d_en      = 1'b1;
                d_res     = make_result(RK_TOKEN, single, p, p, r_row, col, n_tok_cnt, 8'h00);
                n_tok_cnt = sat_inc(n_tok_cnt);
            end else if (b == CH_QUOTE) begin
                n_tok_start = sat_inc(p);
                n_tok_col   = col;
                n_mode      = MODE_STRING;
            end else if (b == CH_MINUS || is_digit(b)) begin
                n_tok_start = p;
                n_tok_col   = col;
                n_mode      = MODE_NUMBER;
            end else if (b == CH_T || b == CH_F || b == CH_N) begin
                n_kw_sel    = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
                n_kw_step   = 3'd1;
                n_tok_start = p;
                n_tok_col   = col;
                n_mode      = MODE_KEYWORD;
            end else if (b == CH_NL) begin
                n_row = sat_inc(r_row);
                n_col = '0;
            end else if (b == CH_SPACE || b == CH_TAB) begin
                // whitespace is skipped
            end else begin
                d_en   = 1'b1;
                d_res  = make_result(RK_ERROR, TK_NONE, p, p, r_row, col, n_tok_cnt, b);
                n_mode = MODE_ERROR;
            end
            if (d_en) begin
                if (rcnt == 2'd0) begin
                    res0 = d_res;
                end else begin
                    res1 = d_res;
                end
                rcnt = rcnt + 2'd1;
            end
        end

        // flag the final result of this byte
        if (rcnt == 2'd2) begin
            res1.last = 1'b1;
        end else if (rcnt == 2'd1) begin
            res0.last = 1'b1;
        end
    end

    assign o_res.count = rcnt;
    assign o_res.r0    = res0;
    assign o_res.r1    = res1;

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_kw_sel    <= KW_TRUE;
            r_kw_step   <= 3'd0;
            r_pos       <= '0;
            r_row       <= t_cnt'(1);
            r_col       <= '0;
            r_tok_start <= '0;
            r_tok_col   <= '0;
            r_tok_cnt   <= '0;
        end else begin
            r_mode      <= n_mode;
            r_kw_sel    <= n_kw_sel;
            r_kw_step   <= n_kw_step;
            r_pos       <= n_pos;
            r_row       <= n_row;
            r_col       <= n_col;
            r_tok_start <= n_tok_start;
            r_tok_col   <= n_tok_col;
            r_tok_cnt   <= n_tok_cnt;
        end
    end

endmodule

@@ design/jbt_out_fifo.sv @@
module jbt_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jbt_pkg::t_res_pair i_push,
    output logic               o_room,
    jbt_out_if.source          o_out
);
    import jbt_pkg::*;

    t_result             r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wp, n_wp;
    logic [Q_PTR_W-1:0]  r_rp, n_rp;
    logic [Q_PTR_W:0]    r_cnt, n_cnt;
    logic [Q_PTR_W-1:0]  wp1;
    logic                pop;
    t_result             head;

    assign pop = o_out.valid && o_out.ready;
    assign wp1 = Q_PTR_W'(r_wp + 1'b1);

    // room for a full pair of results after this cycle's pop
    assign o_room = ((r_cnt - (Q_PTR_W+1)'(pop)) <= (Q_PTR_W+1)'(Q_DEPTH - 2));

    // pointer and fill update
    always_comb begin
        n_wp  = Q_PTR_W'(r_wp + i_push.count);
        n_rp  = Q_PTR_W'(r_rp + pop);
        n_cnt = (Q_PTR_W+1)'(r_cnt + (Q_PTR_W+1)'(i_push.count) - (Q_PTR_W+1)'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_q[r_wp] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_q[wp1] <= i_push.r1;
        end
    end

    // head beat
    assign head                = r_q[r_rp];
    assign o_out.valid         = (r_cnt != '0);
    assign o_out.result_kind   = head.result_kind;
    assign o_out.token_kind    = head.token_kind;
    assign o_out.start_pos     = head.start_pos;
    assign o_out.end_pos       = head.end_pos;
    assign o_out.line_number   = head.line_number;
    assign o_out.column_number = head.column_number;
    assign o_out.token_index   = head.token_index;
    assign o_out.bad_byte      = head.bad_byte;
    assign o_out.last          = head.last;

endmodule

@@ design/json_byte_tokenizer_unit.sv @@
// Flow: a byte accepted at the input is held in the input register and is scanned there
//   once the result queue has room for two results; its results are then written into
//   the queue, whose head entry drives the output handshake.
// Throughput: one byte per cycle; a byte that yields two results needs two output
//   beats, and the four-entry result queue stalls input when it lacks two free slots.
// Reset: synchronous active-low i_rst_n clears the scanner to idle, row 1, all counters
//   to zero, and empties the input register and result queue.
module json_byte_tokenizer_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jbt_in_if.sink    i_in,
    jbt_out_if.source o_out
);
    import jbt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;
    logic       room;
    logic       step;
    t_res_pair  res;

    // a registered byte is scanned when the queue can take two results
    assign step       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

    jbt_lexer_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_data_byte    (r_in_byte),
        .i_end_of_input (r_in_eoi),
        .o_res          (res)
    );

    jbt_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

@@ design/jbt_checker.sv @@
`include "json_byte_tokenizer_unit_defines.svh"

module jbt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_result_kind,
    input logic [3:0] i_out_token_kind,
    input logic       i_out_last
);
    import jbt_pkg::*;

    logic out_acc;
    logic end_beat;

    assign out_acc  = i_out_valid && i_out_ready;
    assign end_beat = i_out_valid && (i_out_result_kind != RK_TOKEN);

    // a stalled beat is not withdrawn
    `JBT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result beat dropped while stalled")

    // nothing follows an error or finished beat until reset
    `JBT_ASSERT_NEXT(a_end_sticky, i_clk, i_rst_n, out_acc && (i_out_result_kind != RK_TOKEN), !i_out_valid, "result after error or finish")

    // error and finished beats carry no token kind
    `JBT_ASSERT_SAME(a_end_no_kind, i_clk, i_rst_n, end_beat, i_out_token_kind == TK_NONE, "token kind on non-token beat")

    // error and finished beats close their byte
    `JBT_ASSERT_SAME(a_end_last, i_clk, i_rst_n, end_beat, i_out_last, "error or finish beat not last")

endmodule

bind json_byte_tokenizer_unit jbt_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_result_kind (o_out.result_kind),
    .i_out_token_kind  (o_out.token_kind),
    .i_out_last        (o_out.last)
);
